/* design/wavetable_interp_oscillator_defines.svh */
// Assertion macros for the wavetable oscillator.
// Taken in by the top level, which writes its checks with them.
`ifndef WAVETABLE_INTERP_OSCILLATOR_DEFINES_SVH
`define WAVETABLE_INTERP_OSCILLATOR_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define WIO_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define WIO_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/wio_pkg.sv */
// Shared types and constants of the wavetable oscillator.
// Used by every module of the block but wio_ram; depends on nothing.
package wio_pkg;

  // Default configuration of the table and the phase accumulator.
  localparam int DEF_TABLE_DEPTH = 4096;
  localparam int DEF_PHASE_BITS  = 24;

  // Fixed field widths of the ports.
  localparam int INDEX_W    = 12;
  localparam int SAMPLE_W   = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;
  localparam int INC_W      = 24;
  localparam int AMP_W      = 15;

  // Register values after reset.
  localparam logic [INC_W-1:0] RST_PHASE_INC = 24'd153791;
  localparam logic [AMP_W-1:0] RST_AMPLITUDE = 15'd6554;

  // Request kinds of the input channel.
  typedef enum logic {
    REQ_LOAD   = 1'b0,
    REQ_SAMPLE = 1'b1
  } req_type_t;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PHASE_INC   = 2'd0,
    REG_AMPLITUDE   = 2'd1,
    REG_START_PHASE = 2'd2
  } cfg_reg_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ2,
    ST_MUL,
    ST_SUM,
    ST_SCALE
  } state_t;

  // Controls of the phase accumulator.
  typedef struct packed {
    logic load;     // load the start phase
    logic capture;  // hold successor address and fraction of this sample
    logic step;     // add the increment
  } phs_ctrl_t;

  // Controls of the interpolation datapath.
  typedef struct packed {
    logic ld_v1;  // first table word is on the read data
    logic mul;    // second word is on the read data, form the slope product
    logic sum;    // add the base word and truncate
  } itp_ctrl_t;

endpackage

/* design/wavetable_interp_oscillator.sv */
// Wavetable oscillator with linear interpolation. A load transaction writes
// one signed 16-bit word into the table and gives no result. A sample
// transaction runs from acceptance to the output register in order: the two
// neighboring table words are read one after the other through the single
// port of the table memory, then the slope product, the sum and the gain
// scaling follow in sequence. One transaction is in work at a time; a
// stalled output holds the next sample back until the output register is
// free. Table entries read before they were written give an undefined
// sample; there is no clearing pass after reset. Writing the start phase
// register loads the phase accumulator; the user must write configuration
// only while idle, and the block does not enforce it.
`include "wavetable_interp_oscillator_defines.svh"

module wavetable_interp_oscillator #(
  parameter int TABLE_DEPTH = wio_pkg::DEF_TABLE_DEPTH,
  parameter int PHASE_BITS  = wio_pkg::DEF_PHASE_BITS
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // Configuration write port.
  input  logic                                cfg_we,
  input  logic [wio_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [wio_pkg::CFG_DATA_W-1:0]      cfg_data,
  // Input channel.
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                in_req_type,
  input  logic [wio_pkg::INDEX_W-1:0]         in_table_index,
  input  logic signed [wio_pkg::SAMPLE_W-1:0] in_table_value,
  input  logic                                in_advance,
  // Result channel.
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [wio_pkg::SAMPLE_W-1:0] out_sample
);
  import wio_pkg::*;

  localparam int ADDR_W    = $clog2(TABLE_DEPTH);
  localparam int IDX_EXT_W = ((ADDR_W > INDEX_W) ? ADDR_W : INDEX_W) + 1;

  state_t                     state_r, state_nxt;
  logic [INC_W-1:0]           phase_inc_r, phase_inc_nxt;
  logic [AMP_W-1:0]           amplitude_r, amplitude_nxt;
  logic                       adv_r;
  logic                       out_valid_r, out_valid_nxt;
  logic signed [SAMPLE_W-1:0] out_sample_r;
  logic                       out_load;
  logic                       start_load;
  logic                       take_sample;
  logic                       take_load;
  logic [IDX_EXT_W-1:0]       idx_ext;
  logic                       idx_in_range;
  logic                       ram_we;
  logic [ADDR_W-1:0]          ram_addr;
  logic signed [SAMPLE_W-1:0] ram_rdata;
  logic [ADDR_W-1:0]          pos_w, nxt_w;
  logic [PHASE_BITS-1:0]      frac_w;
  logic signed [SAMPLE_W-1:0] sample_w;
  phs_ctrl_t                  phs_ctrl;
  itp_ctrl_t                  itp_ctrl;

  // Configuration register decode.
  always_comb begin
    phase_inc_nxt = phase_inc_r;
    amplitude_nxt = amplitude_r;
    start_load    = 1'b0;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_PHASE_INC:   phase_inc_nxt = cfg_data[INC_W-1:0];
        REG_AMPLITUDE:   amplitude_nxt = cfg_data[AMP_W-1:0];
        REG_START_PHASE: start_load    = 1'b1;
        default:         start_load    = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_inc_r <= RST_PHASE_INC;
      amplitude_r <= RST_AMPLITUDE;
    end else begin
      phase_inc_r <= phase_inc_nxt;
      amplitude_r <= amplitude_nxt;
    end
  end

  // Transactions are taken only in the idle state.
  assign take_sample  = in_valid && (state_r == ST_IDLE) && (in_req_type == REQ_SAMPLE);
  assign take_load    = in_valid && (state_r == ST_IDLE) && (in_req_type == REQ_LOAD);
  assign idx_ext      = IDX_EXT_W'(in_table_index);
  assign idx_in_range = idx_ext < IDX_EXT_W'(TABLE_DEPTH);

  // Sequencer next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (take_sample) begin
        state_nxt = ST_READ2;
      end
      ST_READ2: state_nxt = ST_MUL;
      ST_MUL:   state_nxt = ST_SUM;
      ST_SUM:   state_nxt = ST_SCALE;
      ST_SCALE: if (!out_valid_r || !out_stall) begin
        state_nxt = ST_IDLE;
      end
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // Sequencer outputs: table port, datapath strobes and handshakes.
  always_comb begin
    in_stall         = 1'b1;
    ram_we           = 1'b0;
    ram_addr         = nxt_w;
    phs_ctrl.load    = start_load;
    phs_ctrl.capture = 1'b0;
    phs_ctrl.step    = 1'b0;
    itp_ctrl         = '0;
    out_load         = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_stall         = 1'b0;
        ram_addr         = take_load ? idx_ext[ADDR_W-1:0] : pos_w;
        ram_we           = take_load && idx_in_range;
        phs_ctrl.capture = take_sample;
      end
      ST_READ2: begin
        itp_ctrl.ld_v1 = 1'b1;
        phs_ctrl.step  = adv_r;
      end
      ST_MUL:   itp_ctrl.mul = 1'b1;
      ST_SUM:   itp_ctrl.sum = 1'b1;
      ST_SCALE: out_load     = !out_valid_r || !out_stall;
      default:  in_stall     = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Advance flag of the sample in work.
  always_ff @(posedge clk) begin
    if (take_sample) begin
      adv_r <= in_advance;
    end
  end

  // Output register parts the datapath from the result channel.
  assign out_valid_nxt = out_load || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_sample_r <= sample_w;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_sample = out_sample_r;

  // Waveform table.
  wio_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (in_table_value),
    .rdata (ram_rdata)
  );

  // Phase accumulator and addresses.
  wio_phase #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .PHASE_BITS  (PHASE_BITS)
  ) u_phase (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctrl   (phs_ctrl),
    .inc    (phase_inc_r),
    .start  (cfg_data[INC_W-1:0]),
    .pos_o  (pos_w),
    .nxt_o  (nxt_w),
    .frac_o (frac_w)
  );

  // Interpolation and scaling.
  wio_interp #(
    .PHASE_BITS (PHASE_BITS)
  ) u_interp (
    .clk       (clk),
    .ctrl      (itp_ctrl),
    .rdata     (ram_rdata),
    .frac      (frac_w),
    .amplitude (amplitude_r),
    .sample_o  (sample_w)
  );

  // The table is written only while no sample is in work.
  `WIO_ASSERT_SAME(a_write_idle, clk, rst_n, ram_we, state_r == ST_IDLE, "table write outside idle")
  // A new result appears only after the scaling step.
  `WIO_ASSERT_SAME(a_out_from_scale, clk, rst_n, $rose(out_valid_r), $past(state_r) == ST_SCALE, "result without scaling step")
  // The sequencer leaves idle only for an accepted sample transaction.
  `WIO_ASSERT_NEXT(a_idle_hold, clk, rst_n, (state_r == ST_IDLE) && !take_sample, state_r == ST_IDLE, "sequencer left idle without sample")

endmodule

/* design/wio_ram.sv */
// Generic single-port synchronous RAM with a registered read.
// Stand-alone; no package needed.
module wio_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // One access per cycle: a write when enabled, and a registered read (old data on a write).
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    rdata_r <= mem_r[addr];
  end

  assign rdata = rdata_r;

endmodule

/* design/wio_phase.sv */
// Phase accumulator and table address generation.
// Depends on wio_pkg for the control struct and register widths.
module wio_phase #(
  parameter int TABLE_DEPTH = wio_pkg::DEF_TABLE_DEPTH,
  parameter int PHASE_BITS  = wio_pkg::DEF_PHASE_BITS
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  wio_pkg::phs_ctrl_t             ctrl,
  input  logic [wio_pkg::INC_W-1:0]      inc,
  input  logic [wio_pkg::INC_W-1:0]      start,
  output logic [$clog2(TABLE_DEPTH)-1:0] pos_o,
  output logic [$clog2(TABLE_DEPTH)-1:0] nxt_o,
  output logic [PHASE_BITS-1:0]          frac_o
);
  import wio_pkg::*;

  localparam int ADDR_W = $clog2(TABLE_DEPTH);
  localparam int S_W    = PHASE_BITS + $clog2(TABLE_DEPTH + 1);
  localparam int EXT_W  = (PHASE_BITS > INC_W) ? PHASE_BITS : INC_W;

  logic [PHASE_BITS-1:0] phase_r, phase_nxt;
  logic [ADDR_W-1:0]     nxt_r, nxt_w;
  logic [PHASE_BITS-1:0] frac_r;
  logic [EXT_W-1:0]      inc_ext, start_ext;
  logic [S_W-1:0]        s_w;
  logic [ADDR_W-1:0]     pos_w;

  // Register values fitted to the accumulator width.
  assign inc_ext   = EXT_W'(inc);
  assign start_ext = EXT_W'(start);

  // Scale the phase onto the table: the integer part is the position,
  // the low bits are the fraction between two neighboring entries.
  assign s_w   = S_W'(phase_r) * S_W'(TABLE_DEPTH);
  assign pos_w = s_w[PHASE_BITS +: ADDR_W];
  assign nxt_w = (pos_w == ADDR_W'(TABLE_DEPTH - 1)) ? '0 : pos_w + 1'b1;

  // Next phase: a start phase write, or one step modulo the accumulator.
  always_comb begin
    phase_nxt = phase_r;
    if (ctrl.load) begin
      phase_nxt = start_ext[PHASE_BITS-1:0];
    end else if (ctrl.step) begin
      phase_nxt = phase_r + inc_ext[PHASE_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= '0;
    end else begin
      phase_r <= phase_nxt;
    end
  end

  // Successor address and fraction are held for the rest of the transaction.
  always_ff @(posedge clk) begin
    if (ctrl.capture) begin
      nxt_r  <= nxt_w;
      frac_r <= s_w[PHASE_BITS-1:0];
    end
  end

  assign pos_o  = pos_w;
  assign nxt_o  = nxt_r;
  assign frac_o = frac_r;

endmodule

/* design/wio_interp.sv */
// Interpolation and amplitude scaling datapath.
// Depends on wio_pkg for the control struct and sample widths.
module wio_interp #(
  parameter int PHASE_BITS = wio_pkg::DEF_PHASE_BITS
) (
  input  logic                                clk,
  input  wio_pkg::itp_ctrl_t                  ctrl,
  input  logic signed [wio_pkg::SAMPLE_W-1:0] rdata,
  input  logic [PHASE_BITS-1:0]               frac,
  input  logic [wio_pkg::AMP_W-1:0]           amplitude,
  output logic signed [wio_pkg::SAMPLE_W-1:0] sample_o
);
  import wio_pkg::*;

  localparam int DIFF_W = SAMPLE_W + 1;
  localparam int PROD_W = DIFF_W + PHASE_BITS + 1;
  localparam int SUM_W  = PROD_W + 1;
  localparam int SCL_W  = 2 * SAMPLE_W;

  logic signed [SAMPLE_W-1:0] v1_r;
  logic signed [DIFF_W-1:0]   diff_w;
  logic signed [PHASE_BITS:0] frac_s;
  logic signed [PROD_W-1:0]   prod_r, prod_w;
  logic signed [SUM_W-1:0]    num_w;
  logic signed [SAMPLE_W-1:0] v_r;
  logic signed [SAMPLE_W:0]   amp_s;
  logic signed [SCL_W-1:0]    scl_w;

  // Slope between the two neighbors times the fraction.
  assign diff_w = DIFF_W'(rdata) - DIFF_W'(v1_r);
  assign frac_s = $signed({1'b0, frac});
  assign prod_w = PROD_W'(diff_w) * PROD_W'(frac_s);

  // Base word plus slope product; the arithmetic shift floors.
  assign num_w = (SUM_W'(v1_r) <<< PHASE_BITS) + SUM_W'(prod_r);

  always_ff @(posedge clk) begin
    if (ctrl.ld_v1) begin
      v1_r <= rdata;
    end
    if (ctrl.mul) begin
      prod_r <= prod_w;
    end
    if (ctrl.sum) begin
      v_r <= num_w[PHASE_BITS +: SAMPLE_W];
    end
  end

  // Gain in Q0.15, floored; the result always fits 16 bits.
  assign amp_s    = $signed({1'b0, amplitude});
  assign scl_w    = SCL_W'(v_r) * SCL_W'(amp_s);
  assign sample_o = scl_w[AMP_W +: SAMPLE_W];

endmodule
